// ===== hdl/assert_macros.svh =====
// Assertion helper macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/srl_pkg.sv =====
`default_nettype none
package srl_pkg;
    localparam int TIME_W = 56;
    localparam int REQ_W  = 32;
    localparam int IVL_W  = 40;
    localparam int SPL_W  = 16;
    localparam int CFG_W  = 40;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_MAX      = 2'd0;
    localparam logic [IDX_W-1:0] REG_INTERVAL = 2'd1;
    localparam logic [IDX_W-1:0] REG_SPLIT    = 2'd2;

    localparam logic [1:0] VERDICT_NOW  = 2'd0;
    localparam logic [1:0] VERDICT_WAIT = 2'd1;
    localparam logic [1:0] VERDICT_REJ  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] now_ticks;
        logic [REQ_W-1:0]  request_count;
    } t_in;

    typedef struct packed {
        logic [1:0]        verdict;
        logic [TIME_W-1:0] wait_ticks;
    } t_out;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIV_MAX,    // quotient r_num / r_den with 64-bit serial divider
        OP_SEG_NOW,
        OP_DRAIN,
        OP_ADMIT,
        OP_Q_SEGLIM,
        OP_Q_MAX,
        OP_Q_REM,
        OP_WAIT_ACC,
        OP_WAIT_REJ,
        OP_DERIVE_A,
        OP_DERIVE_B,
        OP_DERIVE_FIN
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic disabled;
        logic accept_path;
        logic need_wait;
    } t_sts;
endpackage
`default_nettype wire

// ===== hdl/segmented_rate_limiter.sv =====
// channel  | valid         | stall         | payload
// input    | i_in_valid    | o_in_stall    | i_in_data (t_in)
// output   | o_out_valid   | i_out_stall   | o_out_data (t_out)
// With the limiter disabled a transaction goes straight to its result; an
// accepted one runs two 64-step serial divisions and a rejected one three,
// each path with partial-product multiplies.
// A config write re-derives limits with two divisions.
// Reset is synchronous, active low. A held result stalls only the result
// write of the next transaction; input is still taken.
`default_nettype none
module segmented_rate_limiter #(
    parameter int TIME_BITS = 56,
    parameter int USED_BITS = 48
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [srl_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [srl_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire srl_pkg::t_in              i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output srl_pkg::t_out                  o_out_data
);
    import srl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    srl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    srl_dp #(.TIME_BITS(TIME_BITS), .USED_BITS(USED_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .o_sts      (w_sts),
        .o_res      (o_out_data)
    );
endmodule
`default_nettype wire

// ===== hdl/srl_div.sv =====
`default_nettype none
`include "assert_macros.svh"
module srl_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_busy,
    output logic [63:0]      o_quo,
    output logic [63:0]      o_rem
);
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [63:0] r_q, r_r, r_d;
    logic [64:0] w_trial;

    assign w_trial = {r_r, r_q[63]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
            r_q    <= i_num;
            r_r    <= '0;
            r_d    <= i_den;
        end else if (r_busy) begin
            if (w_trial[64]) begin
                r_r <= {r_r[62:0], r_q[63]};
                r_q <= {r_q[62:0], 1'b0};
            end else begin
                r_r <= w_trial[63:0];
                r_q <= {r_q[62:0], 1'b1};
            end
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;
    assign o_rem  = r_r;

    `ASSERT_NEXT(a_div_start, i_clk, i_rst_n, i_start, r_busy && r_cnt == 7'd64)
    `ASSERT_IMPLY(a_div_cnt, i_clk, i_rst_n, r_busy, r_cnt != 7'd0)
    `ASSERT_NEXT(a_div_done, i_clk, i_rst_n, r_busy && r_cnt == 7'd1 && !i_start, !r_busy)
endmodule
`default_nettype wire

// ===== hdl/srl_dp.sv =====
`default_nettype none
module srl_dp #(
    parameter int TIME_BITS = 56,
    parameter int USED_BITS = 48
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire srl_pkg::t_cmd             i_cmd,
    input  wire logic                      i_cfg_we,
    input  wire logic [srl_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [srl_pkg::CFG_W-1:0] i_cfg_data,
    input  wire srl_pkg::t_in              i_item,
    output srl_pkg::t_sts                  o_sts,
    output srl_pkg::t_out                  o_res
);
    import srl_pkg::*;

    localparam logic [63:0] TMAX = 64'((65'd1 << TIME_BITS) - 65'd1);
    localparam logic [63:0] UMAX = 64'((65'd1 << USED_BITS) - 65'd1);

    logic [REQ_W-1:0] r_max;
    logic [IVL_W-1:0] r_ivl;
    logic [SPL_W-1:0] r_spl;
    logic [REQ_W-1:0] r_seglim;
    logic [IVL_W-1:0] r_segtk;
    logic [USED_BITS-1:0] r_used;
    logic [TIME_BITS-1:0] r_last;
    logic [REQ_W-1:0] r_req;
    logic [63:0] r_t1;
    logic [1:0]  r_verdict;
    logic [TIME_BITS-1:0] r_wait;
    logic        r_acc;

    logic        w_div_start, w_div_busy;
    logic [63:0] r_num, r_den, w_quo, w_rem;

    srl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // saturating 64x64 multiply split into 32-bit partial products over cycles
    logic [1:0]   r_mstep;
    logic         r_mbusy;
    logic [63:0]  r_ma, r_mb, r_mcap;
    logic [127:0] r_macc;
    logic         r_mstart;
    logic [63:0]  w_mres;
    logic [31:0]  w_pa, w_pb;
    logic [63:0]  w_pp;

    always_comb begin
        w_pa = r_mstep[1] ? r_ma[63:32] : r_ma[31:0];
        w_pb = r_mstep[0] ? r_mb[63:32] : r_mb[31:0];
        w_pp = {32'd0, w_pa} * {32'd0, w_pb};
        w_mres = (r_macc > {64'd0, r_mcap}) ? r_mcap : r_macc[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mstep <= '0;
        end else if (r_mstart) begin
            r_mbusy <= 1'b1;
            r_mstep <= '0;
            r_macc  <= '0;
        end else if (r_mbusy) begin
            r_macc  <= r_macc + ({64'd0, w_pp} << (7'(r_mstep[1]) * 7'd32
                                                   + 7'(r_mstep[0]) * 7'd32));
            r_mstep <= r_mstep + 2'd1;
            if (r_mstep == 2'd3) begin
                r_mbusy <= 1'b0;
            end
        end
    end

    assign w_div_start = i_cmd.start && (i_cmd.op == OP_DIV_MAX);

    logic w_dis;
    assign w_dis = (r_ivl == '0) || (r_max == '0) || (r_seglim == '0) || (r_segtk == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= '0;
            r_ivl    <= '0;
            r_spl    <= '0;
            r_seglim <= '0;
            r_segtk  <= '0;
            r_used   <= '0;
            r_last   <= '0;
            r_mstart <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MAX: begin
                        r_max  <= i_cfg_data[REQ_W-1:0];
                        r_used <= '0;
                        r_last <= '0;
                    end
                    REG_INTERVAL: begin
                        r_ivl  <= i_cfg_data[IVL_W-1:0];
                        r_used <= '0;
                        r_last <= '0;
                    end
                    REG_SPLIT: begin
                        r_spl  <= i_cfg_data[SPL_W-1:0];
                        r_used <= '0;
                        r_last <= '0;
                    end
                    default: ;
                endcase
            end else if (i_cmd.start) begin
                unique case (i_cmd.op)
                    OP_DERIVE_A: begin
                        r_num <= {32'd0, r_max};
                        r_den <= {48'd0, r_spl};
                    end
                    OP_DERIVE_B: begin
                        r_t1  <= w_quo;
                        r_num <= {24'd0, r_ivl};
                        r_den <= {48'd0, r_spl};
                    end
                    OP_DERIVE_FIN: begin
                        if (r_ivl == '0) begin
                            r_seglim <= '0;
                            r_segtk  <= '0;
                        end else if (r_spl != '0 && r_t1 != '0 && w_quo != '0) begin
                            r_seglim <= r_t1[REQ_W-1:0];
                            r_segtk  <= w_quo[IVL_W-1:0];
                        end else begin
                            r_seglim <= r_max;
                            r_segtk  <= r_ivl;
                        end
                    end
                    OP_SEG_NOW: begin
                        r_req <= i_item.request_count;
                        r_num <= 64'(i_item.now_ticks[TIME_BITS-1:0]);
                        r_den <= {24'd0, r_segtk};
                    end
                    OP_DRAIN: begin
                        r_t1 <= w_quo;
                        if (w_quo > 64'(r_last)) begin
                            r_ma     <= w_quo - 64'(r_last);
                            r_mb     <= {32'd0, r_seglim};
                            r_mcap   <= '1;
                            r_mstart <= 1'b1;
                        end else begin
                            r_ma     <= '0;
                            r_mb     <= '0;
                            r_mcap   <= '1;
                            r_mstart <= 1'b1;
                        end
                    end
                    OP_ADMIT: begin
                        logic [USED_BITS-1:0] v_used;
                        logic [64:0] v_sum;
                        v_used = (64'(r_used) > w_mres) ? r_used - USED_BITS'(w_mres) : '0;
                        v_sum  = {{(65-USED_BITS){1'b0}}, v_used} + {33'd0, r_req};
                        r_last <= r_t1[TIME_BITS-1:0];
                        r_acc  <= (v_sum <= {33'd0, r_max}) || (r_req > r_max);
                        if ((v_sum <= {33'd0, r_max}) || (r_req > r_max)) begin
                            r_used <= (v_sum > {1'b0, UMAX}) ? '1 : v_sum[USED_BITS-1:0];
                        end else begin
                            r_used <= v_used;
                        end
                    end
                    OP_Q_SEGLIM: begin
                        r_num <= 64'(r_used);
                        r_den <= {32'd0, r_seglim};
                    end
                    OP_Q_MAX: begin
                        r_num <= 64'(r_used);
                        r_den <= {32'd0, r_max};
                    end
                    OP_Q_REM: begin
                        r_ma     <= w_quo;
                        r_mb     <= {24'd0, r_ivl};
                        r_mcap   <= TMAX;
                        r_mstart <= 1'b1;
                        r_num    <= w_rem;
                        r_den    <= {32'd0, r_seglim};
                    end
                    OP_WAIT_ACC: begin
                        r_ma     <= w_quo;
                        r_mb     <= {24'd0, r_segtk};
                        r_mcap   <= TMAX;
                        r_mstart <= 1'b1;
                    end
                    OP_WAIT_REJ: begin
                        r_t1     <= w_mres;
                        r_ma     <= w_quo + 64'd1;
                        r_mb     <= {24'd0, r_segtk};
                        r_mcap   <= TMAX;
                        r_mstart <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // final result formation
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_cmd.op == OP_NONE) begin
            if (w_dis) begin
                r_verdict <= VERDICT_NOW;
                r_wait    <= '0;
            end else if (r_acc) begin
                r_verdict <= (64'(r_used) <= {32'd0, r_seglim}) ? VERDICT_NOW : VERDICT_WAIT;
                r_wait    <= (64'(r_used) <= {32'd0, r_seglim}) ? '0 : w_mres[TIME_BITS-1:0];
            end else begin
                r_verdict <= VERDICT_REJ;
                r_wait    <= ((65'(r_t1) + 65'(w_mres)) > 65'(TMAX)) ? '1
                             : TIME_BITS'(r_t1 + w_mres);
            end
        end
    end

    logic [TIME_W-1:0] w_wait_out;
    assign w_wait_out = TIME_W'(r_wait);

    assign o_sts.busy        = w_div_busy || r_mbusy || r_mstart;
    assign o_sts.disabled    = w_dis;
    assign o_sts.accept_path = r_acc;
    assign o_sts.need_wait   = 64'(r_used) > {32'd0, r_seglim};
    assign o_res.verdict     = r_verdict;
    assign o_res.wait_ticks  = w_wait_out;
endmodule
`default_nettype wire

// ===== hdl/srl_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module srl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire srl_pkg::t_sts  i_sts,
    output srl_pkg::t_cmd       o_cmd
);
    import srl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DA, S_DA_W, S_DB, S_DB_W, S_DFIN,
        S_SEG, S_DRAIN, S_DRAIN_W, S_ADMIT, S_PICK,
        S_QS_W, S_WACC, S_QM_W, S_QREM, S_QREM_W, S_WREJ, S_MUL_W, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_slot;

    // result registers may be overwritten once the held result is gone
    assign w_slot = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.start = 1'b0;
        o_cmd.op    = OP_NONE;
        unique case (r_state)
            S_IDLE:  begin o_cmd.start = i_in_valid && !i_cfg_we; o_cmd.op = OP_SEG_NOW; end
            S_DA:    begin o_cmd.start = 1'b1; o_cmd.op = OP_DERIVE_A; end
            S_DA_W:  begin o_cmd.start = 1'b1; o_cmd.op = OP_DIV_MAX; end
            S_DB:    begin o_cmd.start = !i_sts.busy; o_cmd.op = OP_DERIVE_B; end
            S_DB_W:  begin o_cmd.start = 1'b1; o_cmd.op = OP_DIV_MAX; end
            S_DFIN:  begin o_cmd.start = !i_sts.busy; o_cmd.op = OP_DERIVE_FIN; end
            S_SEG:   begin o_cmd.start = !i_sts.disabled; o_cmd.op = OP_DIV_MAX; end
            S_DRAIN: begin o_cmd.start = !i_sts.busy; o_cmd.op = OP_DRAIN; end
            S_ADMIT: begin o_cmd.start = !i_sts.busy; o_cmd.op = OP_ADMIT; end
            S_PICK:  begin
                o_cmd.start = 1'b1;
                o_cmd.op = i_sts.accept_path ? OP_Q_SEGLIM : OP_Q_MAX;
            end
            S_QS_W, S_QM_W, S_QREM_W: begin o_cmd.start = 1'b1; o_cmd.op = OP_DIV_MAX; end
            S_WACC:  begin o_cmd.start = !i_sts.busy; o_cmd.op = OP_WAIT_ACC; end
            S_QREM:  begin o_cmd.start = !i_sts.busy; o_cmd.op = OP_Q_REM; end
            S_WREJ:  begin o_cmd.start = !i_sts.busy; o_cmd.op = OP_WAIT_REJ; end
            S_FIN:   begin o_cmd.start = !i_sts.busy && w_slot; o_cmd.op = OP_NONE; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_state <= S_DA;
                    end else if (i_in_valid) begin
                        r_state <= S_SEG;
                    end
                end
                S_DA:      r_state <= S_DA_W;
                S_DA_W:    r_state <= S_DB;
                S_DB:      if (!i_sts.busy) r_state <= S_DB_W;
                S_DB_W:    r_state <= S_DFIN;
                S_DFIN:    if (!i_sts.busy) r_state <= S_IDLE;
                S_SEG:     r_state <= i_sts.disabled ? S_FIN : S_DRAIN;
                S_DRAIN:   if (!i_sts.busy) r_state <= S_ADMIT;
                S_ADMIT:   if (!i_sts.busy) r_state <= S_PICK;
                S_PICK:    r_state <= i_sts.accept_path ? S_QS_W : S_QM_W;
                S_QS_W:    r_state <= S_WACC;
                S_WACC:    if (!i_sts.busy) r_state <= i_sts.need_wait ? S_MUL_W : S_FIN;
                S_QM_W:    r_state <= S_QREM;
                S_QREM:    if (!i_sts.busy) r_state <= S_QREM_W;
                S_QREM_W:  r_state <= S_WREJ;
                S_WREJ:    if (!i_sts.busy) r_state <= S_MUL_W;
                S_MUL_W:   r_state <= S_FIN;
                S_FIN:     if (!i_sts.busy && w_slot) r_state <= S_OUT;
                S_OUT:     r_state <= S_IDLE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_we;
    assign o_out_valid = r_out_valid;

    `ASSERT_IMPLY(a_ctl_stall, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `ASSERT_NEXT(a_ctl_take, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid && !i_cfg_we,
                 r_state == S_SEG)
    `ASSERT_NEXT(a_ctl_cfg, i_clk, i_rst_n, r_state == S_IDLE && i_cfg_we, r_state == S_DA)
endmodule
`default_nettype wire

// ===== sim/srl_checker.sv =====
`default_nettype none
module srl_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [srl_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [srl_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire srl_pkg::t_in              i_in_data,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire srl_pkg::t_out             i_out_data,
    output int                             o_errors,
    output int                             o_pending
);
    import srl_pkg::*;

    localparam logic [63:0] ALL1 = '1;
    localparam logic [63:0] TMAX = (64'd1 << TIME_W) - 1;
    localparam logic [63:0] UMAX = (64'd1 << 48) - 1;

    logic [63:0] max_cnt, ivl, split, used, last_seg, seg_lim, seg_ticks;
    t_out        verdict_q[$];

    function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
        if (a == 0 || b == 0) return 0;
        if (b > cap / a) return cap;
        return a * b;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
        if (a > cap || b > cap - a) return cap;
        return a + b;
    endfunction

    task automatic rederive();
        used = 0;
        last_seg = 0;
        seg_lim = 0;
        seg_ticks = 0;
        if (ivl != 0) begin
            if (split != 0) begin
                seg_lim = max_cnt / split;
                seg_ticks = ivl / split;
            end
            if (seg_lim == 0 || seg_ticks == 0) begin
                seg_lim = max_cnt;
                seg_ticks = ivl;
            end
        end
    endtask

    function automatic t_out rate_decision(t_in x);
        t_out        r;
        logic [63:0] now, req, seg_now, drain, w;
        now = 64'(x.now_ticks);
        req = 64'(x.request_count);
        r.verdict = VERDICT_NOW;
        r.wait_ticks = '0;
        if (ivl == 0 || max_cnt == 0 || seg_lim == 0 || seg_ticks == 0) return r;
        seg_now = now / seg_ticks;
        if (seg_now > last_seg) begin
            drain = mul_sat(seg_now - last_seg, seg_lim, ALL1);
            used = (used > drain) ? used - drain : 0;
        end
        last_seg = seg_now;
        if (add_sat(used, req, ALL1) <= max_cnt || req > max_cnt) begin
            used = add_sat(used, req, UMAX);
            if (used <= seg_lim) return r;
            r.verdict = VERDICT_WAIT;
            r.wait_ticks = TIME_W'(mul_sat(seg_ticks, used / seg_lim, TMAX));
            return r;
        end
        w = mul_sat(used / max_cnt, ivl, TMAX);
        w = add_sat(w, mul_sat(1 + (used % max_cnt) / seg_lim, seg_ticks, TMAX), TMAX);
        r.verdict = VERDICT_REJ;
        r.wait_ticks = TIME_W'(w);
        return r;
    endfunction

    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        t_out exp_r;
        int   n_err;
        if (!i_rst_n) begin
            max_cnt = 0;
            ivl = 0;
            split = 0;
            rederive();
            verdict_q.delete();
            o_errors <= 0;
        end else begin
            n_err = 0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX: begin
                        max_cnt = 64'(i_cfg_data[REQ_W-1:0]);
                        rederive();
                    end
                    REG_INTERVAL: begin
                        ivl = 64'(i_cfg_data[IVL_W-1:0]);
                        rederive();
                    end
                    REG_SPLIT: begin
                        split = 64'(i_cfg_data[SPL_W-1:0]);
                        rederive();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) verdict_q.push_back(rate_decision(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected transaction: verdict %0d wait_ticks %0d",
                           i_out_data.verdict, i_out_data.wait_ticks);
                    n_err = n_err + 1;
                end else begin
                    exp_r = verdict_q.pop_front();
                    if (exp_r.verdict !== i_out_data.verdict) begin
                        $error("verdict: expected %0d actual %0d",
                               exp_r.verdict, i_out_data.verdict);
                        n_err = n_err + 1;
                    end
                    if (exp_r.wait_ticks !== i_out_data.wait_ticks) begin
                        $error("wait_ticks: expected %0d actual %0d",
                               exp_r.wait_ticks, i_out_data.wait_ticks);
                        n_err = n_err + 1;
                    end
                end
            end
            o_errors <= o_errors + n_err;
        end
    end
endmodule
`default_nettype wire

// ===== sim/segmented_rate_limiter_test.sv =====
`default_nettype none
module segmented_rate_limiter_test;
    import srl_pkg::*;

    localparam int                LIMIT    = 3000000;
    localparam logic [IDX_W-1:0]  REG_NONE = 2'd3;
    localparam logic [63:0]       TMASK    = (64'd1 << TIME_W) - 1;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [IDX_W-1:0]  i_cfg_idx = REG_MAX;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 0;
    logic              o_in_stall;
    t_in               i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 0;
    t_out              o_out_data;
    int                errors, pending;
    int                cycles = 0;
    int                stall_left = 0;
    bit                quiet = 0;
    logic [63:0]       now = 0, cur_max = 0, cur_ivl = 0, cur_split = 0;

    segmented_rate_limiter DUT (.*);

    srl_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_idle();
        i_in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 0;
        repeat (200) @(posedge i_clk);
    endtask

    task automatic configure(logic [63:0] m, logic [63:0] iv, logic [63:0] sp);
        wait_idle();
        cur_max = m & 64'hFFFF_FFFF;
        cur_ivl = iv & 64'hFF_FFFF_FFFF;
        cur_split = sp & 64'hFFFF;
        write_reg(REG_MAX, m);
        write_reg(REG_INTERVAL, iv);
        write_reg(REG_SPLIT, sp);
        now = 0;
    endtask

    task automatic send(logic [63:0] t, logic [63:0] req);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data.now_ticks <= TIME_W'(t);
        i_in_data.request_count <= REQ_W'(req);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic rand_item();
        logic [63:0] seg, req, step;
        seg = (cur_split != 0 && cur_ivl / cur_split != 0) ? cur_ivl / cur_split : cur_ivl;
        if (seg == 0) seg = 1000;
        case ($urandom_range(0, 9))
            0: step = 0;
            1: step = rnd64();
            2: step = -($urandom_range(0, 3) * seg);
            default: step = seg * $urandom_range(0, 3) + $urandom_range(0, 7);
        endcase
        now = (now + step) & TMASK;
        case ($urandom_range(0, 9))
            0: req = $urandom;
            1: req = cur_max;
            2: req = cur_max + 1;
            3: req = 0;
            default: req = (cur_max == 0) ? $urandom_range(0, 50) :
                           rnd64() % (cur_max / (cur_split == 0 ? 1 : cur_split) * 2 + 2);
        endcase
        send(now, req);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (300) @(posedge i_clk);

        send(TMASK, 64'hFFFF_FFFF);
        send(0, 5);

        configure(100, 1000, 10);
        write_reg(REG_NONE, 64'h12345);
        send(0, 5);
        send(10, 8);
        send(50, 90);
        send(60, 30);
        send(150, 0);
        send(90, 20);
        send(2000, 101);
        send(2000, 64'hFFFF_FFFF);
        send(2050, 1);
        send(TMASK, 7);

        configure(64'hFFFF_FFFF, 64'hFF_FFFF_FFFF, 16'hFFFF);
        send(0, 64'hFFFF_FFFF);
        send(64'hAAAA_AAAA_AAAA_AA, 64'h5555_5555);
        send(TMASK, 64'hFFFF_FFFF);
        send(TMASK, 64'hFFFF_FFFF);
        configure(7, 100, 0);
        send(5, 7);
        send(6, 3);
        configure(3, 100, 40000);
        send(1, 3);
        send(2, 2);
        configure(1, 1, 1);
        send(0, 1);
        send(0, 1);
        send(1, 1);

        for (int ph = 0; ph < 12; ph++) begin
            if (ph >= 10) quiet = 1;
            case ($urandom_range(0, 5))
                0: configure($urandom, rnd64(), $urandom);
                1: configure($urandom_range(0, 1) ? 0 : 50, 500, 5);
                2: configure($urandom_range(1, 200), rnd64() & 64'hFF_FFFF_FFFF,
                             $urandom_range(0, 20));
                default: configure($urandom_range(1, 300), $urandom_range(1, 5000),
                                   $urandom_range(0, 20));
            endcase
            repeat (45) rand_item();
        end
        configure(0, 0, 0);
        send(12345, 6);

        i_in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
